>>> design/dwt53_pkg.sv
`timescale 1ns / 1ps

package dwt53_pkg;

    // Field widths of the sample stream and the coefficient stream
    localparam int unsigned SAMPLE_BITS = 16;
    localparam int unsigned COEF_BITS   = SAMPLE_BITS + 2;
    localparam int unsigned POS_BITS    = 11;

    // Defaults for the top-level parameters
    localparam int unsigned LINE_MAX_DEF    = 4096;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // One input beat
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_of_line;
    } t_in;

    // One output beat
    typedef struct packed {
        logic signed [COEF_BITS-1:0] coefficient;
        logic                        band;
        logic [POS_BITS-1:0]         position;
        logic                        line_done;
    } t_out;

    // Work handed from the front to the back
    typedef enum logic [1:0] {
        JOB_PAIR,      // interior pair: s[p], d[p]
        JOB_PAIR_END,  // odd-length tail: s[p], d[p], s[p+1]
        JOB_ODD_END,   // even-length tail: s[p], d[p] from mirrored x
        JOB_SINGLE     // one-sample line: pass x through
    } t_job_kind;

    typedef struct packed {
        t_job_kind                     kind;
        logic signed [SAMPLE_BITS-1:0] held_even;
        logic signed [SAMPLE_BITS-1:0] held_odd;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [POS_BITS-1:0]           pos;
        logic                          first;   // d[-1] mirrors d[0]
    } t_job;

    // Beat sequencer of the back end
    typedef enum logic [1:0] {
        STEP_S,
        STEP_D,
        STEP_TAIL
    } t_step;

    // Band codes
    localparam logic BAND_LOW  = 1'b0;
    localparam logic BAND_HIGH = 1'b1;

endpackage

>>> design/dwt53_front.sv
`timescale 1ns / 1ps

module dwt53_front #(
    parameter int unsigned LINE_MAX = dwt53_pkg::LINE_MAX_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  dwt53_pkg::t_in  i_data,
    input  logic            i_full,
    output logic            o_push,
    output dwt53_pkg::t_job o_job
);

    localparam int unsigned PC_W  = $clog2(LINE_MAX / 2 + 1);
    localparam int unsigned IDX_W = PC_W + 1;

    logic [PC_W-1:0]                          r_pair;
    logic                                     r_odd;
    logic signed [dwt53_pkg::SAMPLE_BITS-1:0] r_even;
    logic signed [dwt53_pkg::SAMPLE_BITS-1:0] r_held_odd;

    logic [IDX_W-1:0] w_index;
    logic             w_last;
    logic             w_accept;
    logic             w_need;

    // Classify the sample and decide the job
    always_comb begin
        w_index  = {r_pair, r_odd};
        w_last   = i_data.last_of_line || (w_index >= IDX_W'(LINE_MAX - 1));
        o_ready  = !i_full;
        w_accept = i_valid && o_ready;

        o_job.held_even = r_even;
        o_job.held_odd  = r_held_odd;
        o_job.sample    = i_data.sample;
        o_job.pos       = dwt53_pkg::POS_BITS'(r_pair - PC_W'(1));
        o_job.first     = (r_pair == PC_W'(1));
        o_job.kind      = dwt53_pkg::JOB_PAIR;
        w_need          = 1'b0;

        if (r_odd) begin
            o_job.kind  = dwt53_pkg::JOB_ODD_END;
            o_job.pos   = dwt53_pkg::POS_BITS'(r_pair);
            o_job.first = (r_pair == '0);
            w_need      = w_last;
        end else if (r_pair == '0) begin
            o_job.kind = dwt53_pkg::JOB_SINGLE;
            o_job.pos  = '0;
            w_need     = w_last;
        end else begin
            o_job.kind = w_last ? dwt53_pkg::JOB_PAIR_END : dwt53_pkg::JOB_PAIR;
            w_need     = 1'b1;
        end

        o_push = w_accept && w_need;
    end

    // Advance the line position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair <= '0;
            r_odd  <= 1'b0;
        end else if (w_accept) begin
            if (w_last) begin
                r_pair <= '0;
                r_odd  <= 1'b0;
            end else if (r_odd) begin
                r_pair <= r_pair + PC_W'(1);
                r_odd  <= 1'b0;
            end else begin
                r_odd <= 1'b1;
            end
        end
    end

    // Hold the last even and odd samples
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_last) begin
            if (r_odd) begin
                r_held_odd <= i_data.sample;
            end else begin
                r_even <= i_data.sample;
            end
        end
    end

endmodule

>>> design/dwt53_queue.sv
`timescale 1ns / 1ps

module dwt53_queue #(
    parameter int unsigned DEPTH = dwt53_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dwt53_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output dwt53_pkg::t_job o_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    dwt53_pkg::t_job  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    logic w_push;
    logic w_pop;

    always_comb begin
        o_full  = (r_count == CNT_W'(DEPTH));
        o_valid = (r_count != '0);
        o_job   = r_mem[r_rd];
        w_push  = i_push && !o_full;
        w_pop   = i_pop && o_valid;
    end

    // Store the pushed job
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("job pushed into a full queue");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop && r_count != CNT_W'(DEPTH)) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue occupancy lost a push");

endmodule

>>> design/dwt53_back.sv
`timescale 1ns / 1ps

module dwt53_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  dwt53_pkg::t_job i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output dwt53_pkg::t_out o_data
);

    localparam int unsigned SW = dwt53_pkg::SAMPLE_BITS;
    localparam int unsigned CW = dwt53_pkg::COEF_BITS;
    localparam int unsigned AW = CW + 2;

    dwt53_pkg::t_step        r_step;
    dwt53_pkg::t_step        n_step;
    logic                    r_out_valid;
    dwt53_pkg::t_out         r_out;
    logic signed [CW-1:0]    r_prev;

    logic signed [SW:0]      w_sum_ex;
    logic signed [SW:0]      w_half;
    logic signed [CW-1:0]    w_d_pair;
    logic signed [CW-1:0]    w_d_odd;
    logic signed [CW-1:0]    w_d;
    logic signed [CW-1:0]    w_dl;
    logic signed [AW-1:0]    w_acc;
    logic signed [AW-1:0]    w_q;
    logic signed [AW-1:0]    w_acc_tail;
    logic signed [AW-1:0]    w_q_tail;
    logic signed [CW-1:0]    w_s_main;
    logic signed [CW-1:0]    w_s_tail;
    logic                    w_fire;
    logic                    w_job_end;
    dwt53_pkg::t_out         w_beat;

    // Lifting arithmetic on the head job
    always_comb begin
        w_sum_ex   = $signed({i_job.held_even[SW-1], i_job.held_even})
                   + $signed({i_job.sample[SW-1], i_job.sample});
        w_half     = w_sum_ex >>> 1;
        w_d_pair   = $signed({{2{i_job.held_odd[SW-1]}}, i_job.held_odd})
                   - $signed({w_half[SW], w_half});
        w_d_odd    = $signed({{2{i_job.sample[SW-1]}}, i_job.sample})
                   - $signed({{2{i_job.held_even[SW-1]}}, i_job.held_even});
        w_d        = (i_job.kind == dwt53_pkg::JOB_ODD_END) ? w_d_odd : w_d_pair;
        w_dl       = i_job.first ? w_d : r_prev;
        w_acc      = $signed({{2{w_dl[CW-1]}}, w_dl}) + $signed({{2{w_d[CW-1]}}, w_d})
                   + AW'(2);
        w_q        = w_acc >>> 2;
        w_s_main   = $signed({{2{i_job.held_even[SW-1]}}, i_job.held_even}) + w_q[CW-1:0];
        w_acc_tail = $signed({w_d[CW-1], w_d, 1'b0}) + AW'(2);
        w_q_tail   = w_acc_tail >>> 2;
        w_s_tail   = $signed({{2{i_job.sample[SW-1]}}, i_job.sample}) + w_q_tail[CW-1:0];
        w_fire     = i_job_valid && (!r_out_valid || i_ready);
    end

    // Next step of the beat sequencer
    always_comb begin
        n_step = r_step;
        if (w_fire) begin
            unique case (r_step)
                dwt53_pkg::STEP_S: begin
                    n_step = (i_job.kind == dwt53_pkg::JOB_SINGLE) ?
                             dwt53_pkg::STEP_S : dwt53_pkg::STEP_D;
                end
                dwt53_pkg::STEP_D: begin
                    n_step = (i_job.kind == dwt53_pkg::JOB_PAIR_END) ?
                             dwt53_pkg::STEP_TAIL : dwt53_pkg::STEP_S;
                end
                dwt53_pkg::STEP_TAIL: n_step = dwt53_pkg::STEP_S;
                default:              n_step = dwt53_pkg::STEP_S;
            endcase
        end
    end

    // Select the beat for the current step
    always_comb begin
        w_beat.coefficient = w_s_main;
        w_beat.band        = dwt53_pkg::BAND_LOW;
        w_beat.position    = i_job.pos;
        w_beat.line_done   = 1'b0;
        w_job_end          = 1'b0;
        unique case (r_step)
            dwt53_pkg::STEP_S: begin
                if (i_job.kind == dwt53_pkg::JOB_SINGLE) begin
                    w_beat.coefficient = $signed({{2{i_job.sample[SW-1]}}, i_job.sample});
                    w_beat.line_done   = 1'b1;
                    w_job_end          = 1'b1;
                end
            end
            dwt53_pkg::STEP_D: begin
                w_beat.coefficient = w_d;
                w_beat.band        = dwt53_pkg::BAND_HIGH;
                w_beat.line_done   = (i_job.kind == dwt53_pkg::JOB_ODD_END);
                w_job_end          = (i_job.kind != dwt53_pkg::JOB_PAIR_END);
            end
            dwt53_pkg::STEP_TAIL: begin
                w_beat.coefficient = w_s_tail;
                w_beat.position    = i_job.pos + dwt53_pkg::POS_BITS'(1);
                w_beat.line_done   = 1'b1;
                w_job_end          = 1'b1;
            end
            default: begin
                w_job_end = 1'b1;
            end
        endcase
        o_pop   = w_fire && w_job_end;
        o_valid = r_out_valid;
        o_data  = r_out;
    end

    // Advance the sequencer and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= dwt53_pkg::STEP_S;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the output beat and remember d[n] for the next pair
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_beat;
            if (r_step == dwt53_pkg::STEP_D) begin
                r_prev <= w_d;
            end
        end
    end

    a_tail_only_odd_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == dwt53_pkg::STEP_TAIL) |-> (i_job_valid && i_job.kind == dwt53_pkg::JOB_PAIR_END))
        else $error("tail step without an odd-length line end job");

    a_mid_job_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != dwt53_pkg::STEP_S) |-> i_job_valid)
        else $error("job left the queue before all its beats went out");

endmodule

>>> design/forward_dwt_53_lifting_line.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake           Payload
// input    in   i_valid / o_ready   i_data  (dwt53_pkg::t_in)
// output   out  o_valid / i_ready   o_data  (dwt53_pkg::t_out)
//
// One sample is taken per cycle while the job queue has room; an even sample that closes
// a pair, and the last sample of a line, queue a job for the back end.
// The back end drains one beat per cycle while the output is ready: two beats per pair, three
// at an odd-length line end, so on average one coefficient leaves per sample. A job passes
// through the queue and then the back end's output register before its first beat is valid.
// Synchronous active-low reset clears the line position, queue and output valid flag.
// A stalled output holds its beat; the queue (QUEUE_DEPTH jobs) lets input run on.

module forward_dwt_53_lifting_line #(
    parameter int unsigned LINE_MAX    = dwt53_pkg::LINE_MAX_DEF,
    parameter int unsigned QUEUE_DEPTH = dwt53_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  dwt53_pkg::t_in  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output dwt53_pkg::t_out o_data
);

    logic            w_push;
    logic            w_full;
    dwt53_pkg::t_job w_push_job;
    logic            w_pop;
    logic            w_job_valid;
    dwt53_pkg::t_job w_head_job;

    dwt53_front #(
        .LINE_MAX(LINE_MAX)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    dwt53_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_job_valid),
        .o_job   (w_head_job)
    );

    dwt53_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule
